// File: rtl/core/mesh_vertex_normal_generator_assert.svh
// Assertion macros for the mesh vertex normal generator.
`ifndef MESH_VERTEX_NORMAL_GENERATOR_ASSERT_SVH
`define MESH_VERTEX_NORMAL_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define MVNG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MVNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mvng_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package mvng_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TRI   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_START = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_SKIP  = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;
   localparam logic [1:0] STS_RANGE = 2'd3;

   localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_EXEC,
      CMD_RD_POS,
      CMD_EDGE,
      CMD_MUL,
      CMD_VEC,
      CMD_NORM_STEP,
      CMD_NDEF,
      CMD_SQ,
      CMD_SQRT_INIT,
      CMD_SQRT_STEP,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_DIV_DONE,
      CMD_ACC_RD,
      CMD_ACC_WR,
      CMD_RESP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [1:0] sel;
      logic [4:0] step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       tri_ok;
      logic       rd_ok;
      logic       vec_zero;
      logic       norm_hi;
      logic       norm_lo;
   } dp_status_type;

endpackage

// File: rtl/core/mvng_datapath.sv
// Datapath: vertex and accumulator memories, cross product, normalize, sqrt, divide.
module mvng_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mvng_pkg::ctrl_cmd_type cmd,
   output mvng_pkg::dp_status_type stat,
   input  logic [1:0]             req_opcode,
   input  logic [31:0]            req_pos_x,
   input  logic [31:0]            req_pos_y,
   input  logic [31:0]            req_pos_z,
   input  logic [15:0]            req_corner_a,
   input  logic [15:0]            req_corner_b,
   input  logic [15:0]            req_corner_c,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_out_index_a,
   output logic [31:0]            rsp_out_index_b,
   output logic [31:0]            rsp_out_index_c,
   output logic [15:0]            rsp_normal_x,
   output logic [15:0]            rsp_normal_y,
   output logic [15:0]            rsp_normal_z,
   output logic [12:0]            rsp_vertex_total
);
   import mvng_pkg::*;

   // captured request
   logic [1:0]  op_ff;
   logic [15:0] ca_ff, cb_ff, cc_ff;
   logic [95:0] pos_in_ff;
   logic [1:0]  status_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0] base_ff;

   // memories
   logic [95:0] pos_mem [MAX_VERTICES];
   logic [95:0] acc_mem [MAX_VERTICES];
   logic [95:0] pos_q_ff, acc_q_ff;

   logic        pend_ff;
   logic [1:0]  psel_ff;
   logic signed [31:0] p_ff [3][3];
   logic signed [30:0] u_ff [3];
   logic signed [30:0] v_ff [3];
   logic signed [61:0] prod_ff;
   logic signed [62:0] cr_ff [3];
   logic [61:0] m_ff [3];
   logic        sgn_ff [3];
   logic [61:0] sum_ff;
   logic [61:0] x_ff, r_ff, bit_ff;
   logic [45:0] rem_ff;
   logic [15:0] q_ff;
   logic signed [15:0] n_ff [3];

   logic strobe_ff;
   logic [1:0]  rstat_ff;
   logic [31:0] ria_ff, rib_ff, ric_ff;
   logic [15:0] rnx_ff, rny_ff, rnz_ff;
   logic [12:0] rtot_ff;

   // decode
   logic full, tri_ok, rd_ok;
   logic [15:0] csel;
   logic [ADDR_W-1:0] caddr;
   logic pos_we, acc_we;
   logic [ADDR_W-1:0] acc_waddr;
   logic [95:0] acc_wdata, sat_word;

   assign full   = (count_ff == CNT_W'(MAX_VERTICES));
   assign tri_ok = (32'(ca_ff) < 32'(count_ff)) && (32'(cb_ff) < 32'(count_ff))
                   && (32'(cc_ff) < 32'(count_ff));
   assign rd_ok  = (32'(ca_ff) < 32'(count_ff));

   always_comb begin
      case (cmd.sel)
         2'd0:    csel = ca_ff;
         2'd1:    csel = cb_ff;
         default: csel = cc_ff;
      endcase
   end
   assign caddr = csel[ADDR_W-1:0];

   assign pos_we    = (cmd.op == CMD_EXEC) && (op_ff == OP_LOAD) && !full;
   assign acc_we    = pos_we || (cmd.op == CMD_ACC_WR);
   assign acc_waddr = pos_we ? count_ff[ADDR_W-1:0] : caddr;
   assign acc_wdata = pos_we ? 96'd0 : sat_word;

   // saturating add of the face normal onto the read accumulator
   always_comb begin
      logic signed [32:0] s;
      for (int i = 0; i < 3; i++) begin
         s = 33'($signed(acc_q_ff[32*i +: 32])) + 33'(n_ff[i]);
         if (s > 33'sd2147483647)
            sat_word[32*i +: 32] = 32'h7FFF_FFFF;
         else if (s < -33'sd2147483648)
            sat_word[32*i +: 32] = 32'h8000_0000;
         else
            sat_word[32*i +: 32] = s[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we)
         pos_mem[count_ff[ADDR_W-1:0]] <= pos_in_ff;
      pos_q_ff <= pos_mem[caddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we)
         acc_mem[acc_waddr] <= acc_wdata;
      acc_q_ff <= acc_mem[caddr];
   end

   // edge vectors with common right shift
   logic signed [32:0] du [3];
   logic signed [32:0] dv [3];
   logic [32:0] or_mag;
   logic [1:0]  esh;

   always_comb begin
      or_mag = '0;
      for (int i = 0; i < 3; i++) begin
         du[i] = {p_ff[1][i][31], p_ff[1][i]} - {p_ff[0][i][31], p_ff[0][i]};
         dv[i] = {p_ff[2][i][31], p_ff[2][i]} - {p_ff[0][i][31], p_ff[0][i]};
         or_mag = or_mag | (du[i][32] ? 33'(-du[i]) : 33'(du[i]))
                         | (dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]));
      end
      if (or_mag[31])
         esh = 2'd2;
      else if (or_mag[30])
         esh = 2'd1;
      else
         esh = 2'd0;
   end

   // shared multiplier
   logic [3:0] term;
   logic [1:0] sqk;
   logic signed [30:0] mul_a, mul_b;
   logic signed [61:0] mul_p;

   assign term = cmd.step[4:1];
   assign sqk  = cmd.step[2:1];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == CMD_SQ) begin
         mul_a = $signed({1'b0, m_ff[sqk][29:0]});
         mul_b = $signed({1'b0, m_ff[sqk][29:0]});
      end else begin
         case (term)
            4'd0:    begin mul_a = u_ff[1]; mul_b = v_ff[2]; end
            4'd1:    begin mul_a = u_ff[2]; mul_b = v_ff[1]; end
            4'd2:    begin mul_a = u_ff[2]; mul_b = v_ff[0]; end
            4'd3:    begin mul_a = u_ff[0]; mul_b = v_ff[2]; end
            4'd4:    begin mul_a = u_ff[0]; mul_b = v_ff[1]; end
            default: begin mul_a = u_ff[1]; mul_b = v_ff[0]; end
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   // largest magnitude for normalization
   logic [61:0] mx;
   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];
   end

   logic signed [62:0] vsrc [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         vsrc[i] = (op_ff == OP_READ) ? 63'($signed(acc_q_ff[32*i +: 32])) : cr_ff[i];
   end

   logic [61:0] sq_t;
   assign sq_t = r_ff + bit_ff;

   logic [3:0]  dbit;
   logic [46:0] dsub;
   assign dbit = 4'd15 - cmd.step[3:0];
   assign dsub = 47'(r_ff[30:0]) << dbit;

   assign stat.opcode   = op_ff;
   assign stat.tri_ok   = tri_ok;
   assign stat.rd_ok    = rd_ok;
   assign stat.vec_zero = (mx == '0);
   assign stat.norm_hi  = |mx[61:30];
   assign stat.norm_lo  = ~|mx[61:29];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         base_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable)
            base_ff <= csr_write_data;
         pend_ff   <= (cmd.op == CMD_RD_POS);
         strobe_ff <= (cmd.op == CMD_RESP);
         if (cmd.op == CMD_EXEC) begin
            if (pos_we)
               count_ff <= count_ff + CNT_W'(1);
            else if (op_ff == OP_START)
               count_ff <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      psel_ff <= cmd.sel;
      if (pend_ff) begin
         p_ff[psel_ff][0] <= $signed(pos_q_ff[31:0]);
         p_ff[psel_ff][1] <= $signed(pos_q_ff[63:32]);
         p_ff[psel_ff][2] <= $signed(pos_q_ff[95:64]);
      end
      case (cmd.op)
         CMD_CAPTURE: begin
            op_ff     <= req_opcode;
            ca_ff     <= req_corner_a;
            cb_ff     <= req_corner_b;
            cc_ff     <= req_corner_c;
            pos_in_ff <= {req_pos_z, req_pos_y, req_pos_x};
         end
         CMD_EXEC: begin
            case (op_ff)
               OP_LOAD:  status_ff <= full ? STS_FULL : STS_OK;
               OP_TRI:   status_ff <= tri_ok ? STS_OK : STS_SKIP;
               OP_READ:  status_ff <= rd_ok ? STS_OK : STS_RANGE;
               default:  status_ff <= STS_OK;
            endcase
         end
         CMD_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               u_ff[i] <= 31'(du[i] >>> esh);
               v_ff[i] <= 31'(dv[i] >>> esh);
            end
         end
         CMD_MUL: begin
            if (!cmd.step[0])
               prod_ff <= mul_p;
            else if (!term[0])
               cr_ff[term[2:1]] <= 63'(prod_ff);
            else
               cr_ff[term[2:1]] <= cr_ff[term[2:1]] - 63'(prod_ff);
         end
         CMD_VEC: begin
            sum_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               sgn_ff[i] <= vsrc[i][62];
               m_ff[i]   <= vsrc[i][62] ? 62'(-vsrc[i]) : 62'(vsrc[i]);
            end
         end
         CMD_NORM_STEP: begin
            for (int i = 0; i < 3; i++)
               m_ff[i] <= stat.norm_hi ? (m_ff[i] >> 1) : (m_ff[i] << 1);
         end
         CMD_NDEF: begin
            n_ff[0] <= '0;
            n_ff[1] <= '0;
            n_ff[2] <= UNIT_Q14;
         end
         CMD_SQ: begin
            if (!cmd.step[0])
               prod_ff <= mul_p;
            else
               sum_ff <= sum_ff + 62'(prod_ff);
         end
         CMD_SQRT_INIT: begin
            x_ff   <= sum_ff;
            r_ff   <= '0;
            bit_ff <= 62'd1 << 60;
         end
         CMD_SQRT_STEP: begin
            if (x_ff >= sq_t) begin
               x_ff <= x_ff - sq_t;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         CMD_DIV_INIT: begin
            rem_ff <= 46'({m_ff[cmd.sel][29:0], 14'd0}) + 46'(r_ff[30:1]);
            q_ff   <= '0;
         end
         CMD_DIV_STEP: begin
            if ({1'b0, rem_ff} >= dsub) begin
               rem_ff     <= rem_ff - dsub[45:0];
               q_ff[dbit] <= 1'b1;
            end
         end
         CMD_DIV_DONE: begin
            n_ff[cmd.sel] <= sgn_ff[cmd.sel] ? -$signed(q_ff) : $signed(q_ff);
         end
         CMD_RESP: begin
            rstat_ff <= status_ff;
            rtot_ff  <= 13'(count_ff);
            if (op_ff == OP_TRI && status_ff == STS_OK) begin
               ria_ff <= base_ff + 32'(ca_ff);
               rib_ff <= base_ff + 32'(cb_ff);
               ric_ff <= base_ff + 32'(cc_ff);
            end else begin
               ria_ff <= '0;
               rib_ff <= '0;
               ric_ff <= '0;
            end
            if (op_ff == OP_READ && status_ff == STS_OK) begin
               rnx_ff <= n_ff[0];
               rny_ff <= n_ff[1];
               rnz_ff <= n_ff[2];
            end else begin
               rnx_ff <= '0;
               rny_ff <= '0;
               rnz_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = rstat_ff;
   assign rsp_out_index_a  = ria_ff;
   assign rsp_out_index_b  = rib_ff;
   assign rsp_out_index_c  = ric_ff;
   assign rsp_normal_x     = rnx_ff;
   assign rsp_normal_y     = rny_ff;
   assign rsp_normal_z     = rnz_ff;
   assign rsp_vertex_total = rtot_ff;

endmodule

// File: rtl/core/mvng_ctrl.sv
// Controller: sequences each operation through the datapath.
module mvng_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mvng_pkg::dp_status_type stat,
   output mvng_pkg::ctrl_cmd_type  cmd
);
   import mvng_pkg::*;

   typedef enum logic [18:0] {
      S_IDLE   = 19'd1 << 0,
      S_DISP   = 19'd1 << 1,
      S_RDPOS  = 19'd1 << 2,
      S_RDWAIT = 19'd1 << 3,
      S_EDGE   = 19'd1 << 4,
      S_MUL    = 19'd1 << 5,
      S_VEC    = 19'd1 << 6,
      S_NORM   = 19'd1 << 7,
      S_NDEF   = 19'd1 << 8,
      S_SQ     = 19'd1 << 9,
      S_SQI    = 19'd1 << 10,
      S_SQRT   = 19'd1 << 11,
      S_DIVI   = 19'd1 << 12,
      S_DIVS   = 19'd1 << 13,
      S_DIVE   = 19'd1 << 14,
      S_ACCRD  = 19'd1 << 15,
      S_ACCWR  = 19'd1 << 16,
      S_RESP   = 19'd1 << 17,
      S_SPARE  = 19'd1 << 18
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic       is_tri;

   assign is_tri = (stat.opcode == OP_TRI);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      cmd.op   = CMD_NONE;
      cmd.sel  = sel_ff;
      cmd.step = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = CMD_CAPTURE;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.op = CMD_EXEC;
            cnt_in = '0;
            sel_in = '0;
            if (stat.opcode == OP_TRI && stat.tri_ok)
               state_in = S_RDPOS;
            else if (stat.opcode == OP_READ && stat.rd_ok)
               state_in = S_ACCRD;
            else
               state_in = S_RESP;
         end
         S_RDPOS: begin
            cmd.op  = CMD_RD_POS;
            cmd.sel = cnt_ff[1:0];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2)
               state_in = S_RDWAIT;
         end
         S_RDWAIT: state_in = S_EDGE;
         S_EDGE: begin
            cmd.op   = CMD_EDGE;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = CMD_MUL;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd11)
               state_in = S_VEC;
         end
         S_VEC: begin
            cmd.op   = CMD_VEC;
            state_in = S_NORM;
         end
         S_NORM: begin
            cnt_in = '0;
            if (stat.vec_zero)
               state_in = S_NDEF;
            else if (stat.norm_hi || stat.norm_lo)
               cmd.op = CMD_NORM_STEP;
            else
               state_in = S_SQ;
         end
         S_NDEF: begin
            cmd.op   = CMD_NDEF;
            sel_in   = '0;
            state_in = is_tri ? S_ACCRD : S_RESP;
         end
         S_SQ: begin
            cmd.op = CMD_SQ;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd5)
               state_in = S_SQI;
         end
         S_SQI: begin
            cmd.op   = CMD_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = CMD_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            sel_in = '0;
            if (cnt_ff == 5'd30)
               state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.op   = CMD_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.op = CMD_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15)
               state_in = S_DIVE;
         end
         S_DIVE: begin
            cmd.op = CMD_DIV_DONE;
            if (sel_ff == 2'd2) begin
               sel_in   = '0;
               state_in = is_tri ? S_ACCRD : S_RESP;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_DIVI;
            end
         end
         S_ACCRD: begin
            cmd.op   = CMD_ACC_RD;
            state_in = is_tri ? S_ACCWR : S_VEC;
         end
         S_ACCWR: begin
            cmd.op = CMD_ACC_WR;
            if (sel_ff == 2'd2) begin
               state_in = S_RESP;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_ACCRD;
            end
         end
         S_RESP: begin
            cmd.op   = CMD_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// File: rtl/core/mesh_vertex_normal_generator.sv
// Start to rsp_strobe: load, start, skipped triangle and bad read go straight to response.
// Read normal: accumulator read, normalize shifts (0..31), one bit per cycle, squares, sqrt
// (one bit pair per cycle), three 16-step restoring divides on one shared divider; a zero
// vector gives +z. Triangle adds position reads, cross product and accumulator updates.
// Throughput: one item in flight, no output stall; next start taken in the strobe cycle.
// Reset (synchronous, high) clears mesh count, index_base and control; memories keep data.
`include "mesh_vertex_normal_generator_assert.svh"
module mesh_vertex_normal_generator (
   input  logic        clock,
   input  logic        reset,
   // request transfer: start while busy is low
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [15:0] req_corner_a,
   input  logic [15:0] req_corner_b,
   input  logic [15:0] req_corner_c,
   // index_base register
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   // response transfer, one cycle per strobe
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_index_a,
   output logic [31:0] rsp_out_index_b,
   output logic [31:0] rsp_out_index_c,
   output logic [15:0] rsp_normal_x,
   output logic [15:0] rsp_normal_y,
   output logic [15:0] rsp_normal_z,
   output logic [12:0] rsp_vertex_total
);
   import mvng_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // sequencer: one state per phase of the face/vertex normal computation
   mvng_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // memories, multiplier, sqrt and divide, response registers
   mvng_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_index_a  (rsp_out_index_a),
      .rsp_out_index_b  (rsp_out_index_b),
      .rsp_out_index_c  (rsp_out_index_c),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_vertex_total (rsp_vertex_total)
   );

   // response goes out as the sequencer returns to idle
   `MVNG_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "strobe while busy")
   // an accepted request always occupies the sequencer
   `MVNG_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   // failed items carry no normal
   `MVNG_ASSERT_NOW(a_fail_zero, clock, reset, rsp_strobe && rsp_status != STS_OK,
      rsp_normal_x == 16'd0 && rsp_normal_y == 16'd0 && rsp_normal_z == 16'd0,
      "normal on failed item")

endmodule

// File: sim/mesh_vertex_normal_generator_test.sv
// Self-checking testbench for the mesh vertex normal generator: directed and random streams.
module mesh_vertex_normal_generator_test;
   import mvng_pkg::*;

   localparam int CAPACITY = 4096;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_START;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [15:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_index_a, rsp_out_index_b, rsp_out_index_c;
   logic [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [12:0] rsp_vertex_total;

   mesh_vertex_normal_generator dut (.*);

   always #2 clock = ~clock;

   // one expected response
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] ia, ib, ic;
      logic [15:0] nx, ny, nz;
      logic [12:0] total;
   } normal_rsp_type;

   // predictor state: positions, accumulated normals, mesh count, base register
   logic signed [31:0] pos_mem [CAPACITY][3];
   logic signed [31:0] acc_mem [CAPACITY][3];
   int unsigned        mesh_count;
   logic [31:0]        base_reg;

   normal_rsp_type pending_rsps[$];
   int mismatches = 0;
   int rsp_seen   = 0;
   int tri_ok_cnt = 0, read_ok_cnt = 0;
   bit calm       = 0; // long stretch with no idling

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // scale a vector to Q1.14 unit length; zero vector gives +z
   function automatic void unit_scale(input longint c[3], output longint n[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         n[0] = 0; n[1] = 0; n[2] = UNIT_Q14;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 16384 + len / 2) / len;
         n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic void face_normal(int unsigned a, b, c, output longint n[3]);
      longint u[3], v[3], x[3];
      longint unsigned mx;
      int s;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
         v[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
         if (magnitude(u[i]) > mx) mx = magnitude(u[i]);
         if (magnitude(v[i]) > mx) mx = magnitude(v[i]);
      end
      while ((mx >> s) >= (64'd1 << 30)) s++;
      // arithmetic shift floors for negatives
      for (int i = 0; i < 3; i++) begin
         u[i] = u[i] >>> s;
         v[i] = v[i] >>> s;
      end
      x[0] = u[1] * v[2] - u[2] * v[1];
      x[1] = u[2] * v[0] - u[0] * v[2];
      x[2] = u[0] * v[1] - u[1] * v[0];
      unit_scale(x, n);
   endfunction

   function automatic void add_saturating(int unsigned idx, longint n[3]);
      longint s;
      for (int i = 0; i < 3; i++) begin
         s = longint'(acc_mem[idx][i]) + n[i];
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         acc_mem[idx][i] = s[31:0];
      end
   endfunction

   function automatic normal_rsp_type predict_normal_rsp(logic [1:0] op,
                                                          logic [31:0] px, py, pz,
                                                          logic [15:0] ca, cb, cc);
      normal_rsp_type r;
      longint f[3], a[3];
      r = '0;
      case (op)
         OP_LOAD: begin
            if (mesh_count >= CAPACITY) begin
               r.status = STS_FULL;
            end else begin
               pos_mem[mesh_count][0] = px;
               pos_mem[mesh_count][1] = py;
               pos_mem[mesh_count][2] = pz;
               for (int i = 0; i < 3; i++) acc_mem[mesh_count][i] = 0;
               mesh_count++;
            end
         end
         OP_TRI: begin
            if (ca >= mesh_count || cb >= mesh_count || cc >= mesh_count) begin
               r.status = STS_SKIP;
            end else begin
               face_normal(ca, cb, cc, f);
               add_saturating(ca, f);
               add_saturating(cb, f);
               add_saturating(cc, f);
               r.ia = base_reg + ca;
               r.ib = base_reg + cb;
               r.ic = base_reg + cc;
               tri_ok_cnt++;
            end
         end
         OP_READ: begin
            if (ca >= mesh_count) begin
               r.status = STS_RANGE;
            end else begin
               for (int i = 0; i < 3; i++) a[i] = acc_mem[ca][i];
               unit_scale(a, f);
               r.nx = f[0][15:0];
               r.ny = f[1][15:0];
               r.nz = f[2][15:0];
               read_ok_cnt++;
            end
         end
         default: mesh_count = 0;
      endcase
      r.total = mesh_count[12:0];
      return r;
   endfunction

   // response checker: every strobe is one transfer
   always @(posedge clock) begin
      normal_rsp_type got, want;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         got = '{rsp_status, rsp_out_index_a, rsp_out_index_b, rsp_out_index_c,
                 rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_vertex_total};
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp sts=%0d idx=%h/%h/%h n=%h/%h/%h tot=%0d",
                           want.status, want.ia, want.ib, want.ic, want.nx, want.ny,
                           want.nz, want.total);
                  $display("          got sts=%0d idx=%h/%h/%h n=%h/%h/%h tot=%0d",
                           got.status, got.ia, got.ib, got.ic, got.nx, got.ny,
                           got.nz, got.total);
               end
            end
         end
      end
   end

   // drive one command and hold until it is taken
   task automatic send_cmd(logic [1:0] op, logic [31:0] px = 0, py = 0, pz = 0,
                           logic [15:0] ca = 0, cb = 0, cc = 0);
      normal_rsp_type exp_rsp;
      while (!calm && $urandom_range(99) < 29) @(posedge clock);
      start        <= 1'b1;
      req_opcode   <= op;
      req_pos_x    <= px;
      req_pos_y    <= py;
      req_pos_z    <= pz;
      req_corner_a <= ca;
      req_corner_b <= cb;
      req_corner_c <= cc;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_rsp = predict_normal_rsp(op, px, py, pz, ca, cb, cc);
      pending_rsps = {pending_rsps, exp_rsp};
      start <= 1'b0;
      @(posedge clock);
   endtask

   // wait for the block to drain before a register write
   task automatic drain();
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      base_reg = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(2000)) - 1000) << 12;
      endcase
   endfunction

   task automatic test_directed();
      write_base(32'hFFFF_FFFE);
      send_cmd(OP_TRI, 0, 0, 0, 0, 0, 0);        // empty mesh: skipped
      send_cmd(OP_READ, 0, 0, 0, 0);             // read out of range
      send_cmd(OP_LOAD, 0, 0, 0);
      send_cmd(OP_LOAD, 32'h0001_0000, 0, 0);
      send_cmd(OP_LOAD, 0, 32'h0001_0000, 0);
      send_cmd(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_cmd(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_cmd(OP_READ, 0, 0, 0, 0);             // zero accumulator
      send_cmd(OP_TRI, 0, 0, 0, 0, 1, 2);        // wraps past the base
      send_cmd(OP_TRI, 0, 0, 0, 0, 0, 0);        // degenerate
      send_cmd(OP_TRI, 0, 0, 0, 3, 4, 0);        // huge edges
      send_cmd(OP_TRI, 0, 0, 0, 1, 2, 16'hFFFF); // corner out of range
      send_cmd(OP_READ, 0, 0, 0, 0);
      send_cmd(OP_READ, 0, 0, 0, 3);
      send_cmd(OP_READ, 0, 0, 0, 16'hFFFF);
      send_cmd(OP_START);
      send_cmd(OP_READ, 0, 0, 0, 0);
      write_base(32'h0);
   endtask

   // many faces piled onto one fan back to back, then reads around the mesh end
   task automatic test_shared_fan();
      calm = 1;
      send_cmd(OP_START);
      send_cmd(OP_LOAD, 0, 0, 0);
      send_cmd(OP_LOAD, 32'h0010_0000, 0, 0);
      send_cmd(OP_LOAD, 0, 32'h0010_0000, 0);
      repeat (140) send_cmd(OP_TRI, 0, 0, 0, 0, 1, 2);
      send_cmd(OP_READ, 0, 0, 0, 0);
      send_cmd(OP_READ, 0, 0, 0, 16'd2);
      send_cmd(OP_READ, 0, 0, 0, 16'd3);         // just past the mesh
      calm = 0;
   endtask

   task automatic test_random_meshes(int items);
      int sent, lim;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(3) == 0) write_base($urandom);
         send_cmd(OP_START);
         sent++;
         repeat ($urandom_range(3, 12)) begin
            send_cmd(OP_LOAD, rand_coord(), rand_coord(), rand_coord());
            sent++;
         end
         repeat ($urandom_range(10, 30)) begin
            lim = mesh_count + 1;
            case ($urandom_range(9))
               0: send_cmd(OP_LOAD, rand_coord(), rand_coord(), rand_coord());
               1: send_cmd(OP_TRI, $urandom, $urandom, $urandom,
                           16'($urandom), 16'($urandom), 16'($urandom));
               2, 3: send_cmd(OP_READ, $urandom, $urandom, $urandom,
                              16'($urandom_range(lim)), 16'($urandom), 16'($urandom));
               default: send_cmd(OP_TRI, $urandom, $urandom, $urandom,
                                 16'($urandom_range(lim - 1)), 16'($urandom_range(lim - 1)),
                                 16'($urandom_range(lim)));
            endcase
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_shared_fan();
      test_random_meshes(900);
      calm = 1;
      test_random_meshes(150);
      calm = 0;
      write_base(32'hFFFF_FFFF);
      test_random_meshes(700);
      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d responses: %0d good triangles, %0d normal reads",
               rsp_seen, tri_ok_cnt, read_ok_cnt);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("PASS mesh_vertex_normal_generator");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, pending_rsps.size());
         $display("FAIL mesh_vertex_normal_generator");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("timeout");
      $display("FAIL mesh_vertex_normal_generator");
      $finish;
   end
endmodule
